// ===== sv/tss_pkg.sv =====
// Shared types, constants and helper functions of the tabu search step unit.
`timescale 1ns / 1ps

package tss_pkg;

    localparam int MAX_CITIES = 64;
    localparam int TABU_DEPTH = 16;
    localparam int DIST_BITS  = 16;
    localparam int CITY_W     = 6;
    localparam int POS_W      = 7;
    localparam int COST_W     = 22;
    localparam int DELTA_W    = 24;
    localparam int ACC_W      = 26;
    localparam int TEN_W      = 5;
    localparam int STALL_W    = 16;
    localparam int SLOT_W     = $clog2(TABU_DEPTH);
    localparam int DADDR_W    = 2 * CITY_W;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef enum logic [2:0] {
        CMD_LOAD_DIST = 3'd0,
        CMD_LOAD_TOUR = 3'd1,
        CMD_BEGIN     = 3'd2,
        CMD_STEP      = 3'd3,
        CMD_READ_CUR  = 3'd4,
        CMD_READ_BEST = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        NB_REVERSE = 2'd0,
        NB_SWAP    = 2'd1,
        NB_INSERT  = 2'd2
    } nbhd_t;

    typedef enum logic [1:0] {
        CFG_NEIGHBORHOOD = 2'd0,
        CFG_CITY_COUNT   = 2'd1,
        CFG_TENURE       = 2'd2,
        CFG_DIVISOR      = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PS_IM1,
        PS_I,
        PS_IP1,
        PS_JM1,
        PS_J,
        PS_JP1
    } pos_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_COPY,
        ST_TERM_P,
        ST_TERM_Q,
        ST_TERM_D,
        ST_TERM_ACC,
        ST_EVAL,
        ST_SW_RX,
        ST_SW_RY,
        ST_SW_WX,
        ST_SW_WY,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } state_t;

    // One distance term of a move's cost change: sign * dist(tour[p], tour[q])
    typedef struct packed {
        pos_sel_t p_sel;
        pos_sel_t q_sel;
        logic     neg;
        logic     to_s;
    } term_t;

    typedef struct packed {
        logic              clear;
        logic              record;
        logic [CITY_W-1:0] city_a;
        logic [CITY_W-1:0] city_b;
        logic [TEN_W-1:0]  tenure;
    } tabu_ctl_t;

    function automatic term_t mk(pos_sel_t p, pos_sel_t q, logic neg, logic to_s);
        term_t r;
        r.p_sel = p;
        r.q_sel = q;
        r.neg   = neg;
        r.to_s  = to_s;
        return r;
    endfunction

    // Term lists per move kind. Reversal keeps the running segment sum in
    // a separate accumulator that carries over from one j to the next.
    function automatic term_t term_of(logic [1:0] kind, logic adj, logic [2:0] t);
        term_t r;
        r = mk(PS_I, PS_J, 1'b0, 1'b0);
        if (kind == NB_REVERSE)
        begin
            case (t)
                3'd0:    r = mk(PS_J,   PS_JM1, 1'b0, 1'b1);
                3'd1:    r = mk(PS_JM1, PS_J,   1'b1, 1'b1);
                3'd2:    r = mk(PS_IM1, PS_I,   1'b1, 1'b0);
                3'd3:    r = mk(PS_J,   PS_JP1, 1'b1, 1'b0);
                3'd4:    r = mk(PS_IM1, PS_J,   1'b0, 1'b0);
                default: r = mk(PS_I,   PS_JP1, 1'b0, 1'b0);
            endcase
        end
        else if (kind == NB_SWAP && adj)
        begin
            case (t)
                3'd0:    r = mk(PS_IM1, PS_I,   1'b1, 1'b0);
                3'd1:    r = mk(PS_I,   PS_J,   1'b1, 1'b0);
                3'd2:    r = mk(PS_J,   PS_JP1, 1'b1, 1'b0);
                3'd3:    r = mk(PS_IM1, PS_J,   1'b0, 1'b0);
                3'd4:    r = mk(PS_J,   PS_I,   1'b0, 1'b0);
                default: r = mk(PS_I,   PS_JP1, 1'b0, 1'b0);
            endcase
        end
        else if (kind == NB_SWAP)
        begin
            case (t)
                3'd0:    r = mk(PS_IM1, PS_I,   1'b1, 1'b0);
                3'd1:    r = mk(PS_I,   PS_IP1, 1'b1, 1'b0);
                3'd2:    r = mk(PS_JM1, PS_J,   1'b1, 1'b0);
                3'd3:    r = mk(PS_J,   PS_JP1, 1'b1, 1'b0);
                3'd4:    r = mk(PS_IM1, PS_J,   1'b0, 1'b0);
                3'd5:    r = mk(PS_J,   PS_IP1, 1'b0, 1'b0);
                3'd6:    r = mk(PS_JM1, PS_I,   1'b0, 1'b0);
                default: r = mk(PS_I,   PS_JP1, 1'b0, 1'b0);
            endcase
        end
        else
        begin
            case (t)
                3'd0:    r = mk(PS_I,   PS_IP1, 1'b1, 1'b0);
                3'd1:    r = mk(PS_JM1, PS_J,   1'b1, 1'b0);
                3'd2:    r = mk(PS_IM1, PS_I,   1'b1, 1'b0);
                3'd3:    r = mk(PS_IM1, PS_IP1, 1'b0, 1'b0);
                3'd4:    r = mk(PS_JM1, PS_I,   1'b0, 1'b0);
                default: r = mk(PS_I,   PS_J,   1'b0, 1'b0);
            endcase
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pos_of(pos_sel_t s, logic [POS_W-1:0] i,
                                                 logic [POS_W-1:0] j);
        logic [POS_W-1:0] r;
        unique case (s)
            PS_IM1: r = i - POS_W'(1);
            PS_I:   r = i;
            PS_IP1: r = i + POS_W'(1);
            PS_JM1: r = j - POS_W'(1);
            PS_J:   r = j;
            PS_JP1: r = j + POS_W'(1);
        endcase
        return r;
    endfunction

    function automatic logic [TEN_W-1:0] clamp_tenure(logic [TEN_W-1:0] t);
        logic [TEN_W-1:0] r;
        if (t == '0)
            r = TEN_W'(1);
        else if (t > TEN_W'(TABU_DEPTH))
            r = TEN_W'(TABU_DEPTH);
        else
            r = t;
        return r;
    endfunction

endpackage

// ===== sv/tss_if.sv =====
// Request and response channel interfaces of the tabu search step unit.
`timescale 1ns / 1ps

interface tss_req_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    command;
    logic [tss_pkg::CITY_W-1:0]    from_city;
    logic [tss_pkg::CITY_W-1:0]    to_city;
    logic [tss_pkg::DIST_BITS-1:0] distance;
    logic [tss_pkg::POS_W-1:0]     route_position;
    logic [tss_pkg::CITY_W-1:0]    route_city;
    logic [tss_pkg::COST_W-1:0]    initial_cost;

    modport source (output valid, command, from_city, to_city, distance,
                    route_position, route_city, initial_cost, input ready);
    modport sink (input valid, command, from_city, to_city, distance,
                  route_position, route_city, initial_cost, output ready);
endinterface

interface tss_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              move_found;
    logic [tss_pkg::POS_W-1:0]         move_first;
    logic [tss_pkg::POS_W-1:0]         move_second;
    logic signed [tss_pkg::DELTA_W-1:0] move_delta;
    logic [tss_pkg::COST_W-1:0]        current_cost;
    logic [tss_pkg::COST_W-1:0]        best_cost;
    logic                              improved;
    logic [tss_pkg::STALL_W-1:0]       stall_count;
    logic [tss_pkg::CITY_W-1:0]        read_city;

    modport source (output valid, move_found, move_first, move_second, move_delta,
                    current_cost, best_cost, improved, stall_count, read_city,
                    input ready);
    modport sink (input valid, move_found, move_first, move_second, move_delta,
                  current_cost, best_cost, improved, stall_count, read_city,
                  output ready);
endinterface

// ===== sv/tss_dist_ram.sv =====
// Distance matrix memory: one write port, one registered read port.
`timescale 1ns / 1ps

module tss_dist_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [tss_pkg::DADDR_W-1:0]   waddr,
    input  logic [tss_pkg::DIST_BITS-1:0] wdata,
    input  logic [tss_pkg::DADDR_W-1:0]   raddr,
    output logic [tss_pkg::DIST_BITS-1:0] rdata
);

    logic [tss_pkg::DIST_BITS-1:0] mem [tss_pkg::MAX_CITIES*tss_pkg::MAX_CITIES];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/tss_tour_ram.sv =====
// Current and best tour memories, each with one write and one registered read port.
`timescale 1ns / 1ps

module tss_tour_ram (
    input  logic                       clk,
    input  logic                       cur_we,
    input  logic [tss_pkg::POS_W-1:0]  cur_waddr,
    input  logic [tss_pkg::CITY_W-1:0] cur_wdata,
    input  logic [tss_pkg::POS_W-1:0]  cur_raddr,
    output logic [tss_pkg::CITY_W-1:0] cur_rdata,
    input  logic                       best_we,
    input  logic [tss_pkg::POS_W-1:0]  best_waddr,
    input  logic [tss_pkg::CITY_W-1:0] best_wdata,
    input  logic [tss_pkg::POS_W-1:0]  best_raddr,
    output logic [tss_pkg::CITY_W-1:0] best_rdata
);

    logic [tss_pkg::CITY_W-1:0] cur_mem  [tss_pkg::MAX_CITIES+1];
    logic [tss_pkg::CITY_W-1:0] best_mem [tss_pkg::MAX_CITIES+1];

    always_ff @(posedge clk)
    begin
        if (cur_we)
            cur_mem[cur_waddr] <= cur_wdata;
        cur_rdata <= cur_mem[cur_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (best_we)
            best_mem[best_waddr] <= best_wdata;
        best_rdata <= best_mem[best_raddr];
    end

endmodule

// ===== sv/tss_tabu.sv =====
// Tabu list: pair lookup, aging and insertion into the first free slot.
`timescale 1ns / 1ps

module tss_tabu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tss_pkg::tabu_ctl_t         ctl,
    input  logic [tss_pkg::CITY_W-1:0] query_a,
    input  logic [tss_pkg::CITY_W-1:0] query_b,
    output logic                       hit_ab,
    output logic                       hit_ba
);

    logic [tss_pkg::CITY_W-1:0] city_a_reg [tss_pkg::TABU_DEPTH];
    logic [tss_pkg::CITY_W-1:0] city_b_reg [tss_pkg::TABU_DEPTH];
    logic [tss_pkg::TEN_W-1:0]  remain_reg [tss_pkg::TABU_DEPTH];
    logic [tss_pkg::TEN_W-1:0]  aged       [tss_pkg::TABU_DEPTH];
    logic [tss_pkg::SLOT_W-1:0] slot;
    logic                       slot_found;

    always_comb
    begin
        hit_ab = 1'b0;
        hit_ba = 1'b0;
        for (int k = 0; k < tss_pkg::TABU_DEPTH; k++)
        begin
            if (remain_reg[k] != '0 && city_a_reg[k] == query_a && city_b_reg[k] == query_b)
                hit_ab = 1'b1;
            if (remain_reg[k] != '0 && city_a_reg[k] == query_b && city_b_reg[k] == query_a)
                hit_ba = 1'b1;
        end
    end

    // age first, then pick the lowest free slot (slot 0 if none is free)
    always_comb
    begin
        slot       = '0;
        slot_found = 1'b0;
        for (int k = 0; k < tss_pkg::TABU_DEPTH; k++)
        begin
            aged[k] = (remain_reg[k] != '0) ? remain_reg[k] - tss_pkg::TEN_W'(1) : '0;
            if (!slot_found && aged[k] == '0)
            begin
                slot       = tss_pkg::SLOT_W'(k);
                slot_found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < tss_pkg::TABU_DEPTH; k++)
                remain_reg[k] <= '0;
        end
        else if (ctl.clear)
        begin
            for (int k = 0; k < tss_pkg::TABU_DEPTH; k++)
                remain_reg[k] <= '0;
        end
        else if (ctl.record)
        begin
            for (int k = 0; k < tss_pkg::TABU_DEPTH; k++)
                remain_reg[k] <= (tss_pkg::SLOT_W'(k) == slot) ? ctl.tenure : aged[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.record && !ctl.clear)
        begin
            city_a_reg[slot] <= ctl.city_a;
            city_b_reg[slot] <= ctl.city_b;
        end
    end

endmodule

// ===== sv/tabu_search_tour_move_step_unit.sv =====
// Top level: command sequencer, move scan, move application and result register.
`timescale 1ns / 1ps

// One item at a time. Loads go straight to the result, reads pass RD_WAIT first, and begin
// copies the current tour into the best tour. A step evaluates each candidate pair
// as 6 distance terms (8 for a non-adjacent swap), each through the states TERM_P,
// TERM_Q, TERM_D and TERM_ACC, then the EVAL state, because every term needs two
// tour reads and one distance read through single read ports.
// Applying the move runs SW_RX, SW_RY, SW_WX and SW_WY per exchanged pair of
// positions; an improving step adds the tour copy and a tenure division.
// The result sits in an output register; the next item is taken meanwhile.
module tabu_search_tour_move_step_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data,
    tss_req_if.sink    req,
    tss_rsp_if.source  rsp
);

    localparam int PW = tss_pkg::POS_W;
    localparam int AW = tss_pkg::ACC_W;
    localparam int CW = tss_pkg::CITY_W;
    localparam int TW = tss_pkg::TEN_W;

    tss_pkg::state_t state_reg, state_next;

    logic [1:0]                   neighborhood_reg;
    logic [PW-1:0]                city_count_reg;
    logic [TW-1:0]                tabu_tenure_reg;
    logic [TW-1:0]                intensify_divisor_reg;
    logic [tss_pkg::COST_W-1:0]   current_cost_reg, best_cost_reg;
    logic [TW-1:0]                active_tenure_reg;
    logic [tss_pkg::STALL_W-1:0]  stall_counter_reg;

    logic [2:0]          cmd_reg;
    logic [PW-1:0]       pos_reg;
    logic [PW-1:0]       i_reg, j_reg;
    logic [2:0]          t_reg;
    logic [CW-1:0]       city_p_reg, ca_reg, cb_reg, best_ca_reg, best_cb_reg;
    logic signed [AW-1:0] acc_reg, s_acc_reg, bestd_reg;
    logic                have_reg;
    logic [PW-1:0]       bi_reg, bj_reg;
    logic [PW-1:0]       sw_x_reg, sw_y_reg;
    logic [CW-1:0]       sw_t_reg;
    logic [PW-1:0]       cp_reg;
    logic                copy_div_reg;
    logic [TW-1:0]       div_num_reg, div_rem_reg, div_q_reg;
    logic [2:0]          div_cnt_reg;
    logic                res_found_reg, res_improved_reg;
    logic [CW-1:0]       res_city_reg;

    logic                          out_valid_reg;
    logic                          out_found_reg, out_improved_reg;
    logic [PW-1:0]                 out_first_reg, out_second_reg;
    logic signed [tss_pkg::DELTA_W-1:0] out_delta_reg;
    logic [tss_pkg::COST_W-1:0]    out_cur_reg, out_best_reg;
    logic [tss_pkg::STALL_W-1:0]   out_stall_reg;
    logic [CW-1:0]                 out_city_reg;

    // memory and tabu ports
    logic                          dist_we;
    logic [tss_pkg::DADDR_W-1:0]   dist_waddr, dist_raddr;
    logic [tss_pkg::DIST_BITS-1:0] dist_rdata;
    logic                          cur_we, best_we;
    logic [PW-1:0]                 cur_waddr, cur_raddr, best_waddr, best_raddr;
    logic [CW-1:0]                 cur_wdata, cur_rdata, best_rdata;
    tss_pkg::tabu_ctl_t            tabu_ctl;
    logic                          hit_ab, hit_ba;

    // combinational helpers
    logic                 accept, out_load;
    logic [PW-1:0]        n_eff, req_pos;
    logic                 adj;
    tss_pkg::term_t       term;
    logic [2:0]           t_last;
    logic [PW-1:0]        p_pos, q_pos;
    tss_pkg::pos_sel_t    cb_sel;
    logic signed [AW-1:0] delta_c, dist_term;
    logic signed [AW:0]   cur_ext, best_ext, trial, nc_full;
    logic                 beats, tabu_c, take, have_after;
    logic [PW-1:0]        jc, i_nx, j_nx, bi_f, bj_f;
    logic                 row_end, scan_last;
    logic [PW-1:0]        sw_x_init, sw_y_init, sw_x_nx, sw_y_nx;
    logic                 sw_more;
    logic [tss_pkg::COST_W-1:0] nc_sat;
    logic                 improved_c;
    logic [TW-1:0]        dvs, div_rem_nx, div_q_nx;
    logic [TW:0]          div_sh;
    logic                 div_ge;

    function automatic logic [PW-1:0] first_j(logic [1:0] kind, logic [PW-1:0] i);
        logic [PW-1:0] r;
        if (kind == tss_pkg::NB_INSERT)
        begin
            if (i == PW'(1))
                r = PW'(3);
            else if (i == PW'(2))
                r = PW'(4);
            else
                r = PW'(1);
        end
        else
            r = i + PW'(1);
        return r;
    endfunction

    tss_dist_ram u_dist (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (req.distance),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    tss_tour_ram u_tour (
        .clk        (clk),
        .cur_we     (cur_we),
        .cur_waddr  (cur_waddr),
        .cur_wdata  (cur_wdata),
        .cur_raddr  (cur_raddr),
        .cur_rdata  (cur_rdata),
        .best_we    (best_we),
        .best_waddr (best_waddr),
        .best_wdata (cur_rdata),
        .best_raddr (best_raddr),
        .best_rdata (best_rdata)
    );

    tss_tabu u_tabu (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tabu_ctl),
        .query_a (ca_reg),
        .query_b (cb_reg),
        .hit_ab  (hit_ab),
        .hit_ba  (hit_ba)
    );

    assign accept   = req.valid && req.ready;
    assign out_load = (state_reg == tss_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);
    assign req_pos  = (req.route_position > PW'(tss_pkg::MAX_CITIES)) ? '0 : req.route_position;

    // scan datapath
    always_comb
    begin
        if (city_count_reg < PW'(4))
            n_eff = PW'(4);
        else if (city_count_reg > PW'(tss_pkg::MAX_CITIES))
            n_eff = PW'(tss_pkg::MAX_CITIES);
        else
            n_eff = city_count_reg;

        adj    = (j_reg == i_reg + PW'(1));
        term   = tss_pkg::term_of(neighborhood_reg, adj, t_reg);
        t_last = (neighborhood_reg == tss_pkg::NB_SWAP && !adj) ? 3'd7 : 3'd5;
        p_pos  = tss_pkg::pos_of(term.p_sel, i_reg, j_reg);
        q_pos  = tss_pkg::pos_of(term.q_sel, i_reg, j_reg);
        cb_sel = (neighborhood_reg == tss_pkg::NB_INSERT) ? tss_pkg::PS_JM1 : tss_pkg::PS_J;

        dist_term = $signed({{(AW-tss_pkg::DIST_BITS){1'b0}}, dist_rdata});
        delta_c   = acc_reg + s_acc_reg;
        cur_ext   = $signed({{(AW+1-tss_pkg::COST_W){1'b0}}, current_cost_reg});
        best_ext  = $signed({{(AW+1-tss_pkg::COST_W){1'b0}}, best_cost_reg});
        trial     = cur_ext + {delta_c[AW-1], delta_c};
        beats     = trial < best_ext;
        tabu_c    = hit_ab || (neighborhood_reg != tss_pkg::NB_INSERT && hit_ba);
        take      = (!tabu_c || beats) && (!have_reg || delta_c < bestd_reg);
        have_after = have_reg || take;
        bi_f      = take ? i_reg : bi_reg;
        bj_f      = take ? j_reg : bj_reg;

        if (neighborhood_reg == tss_pkg::NB_INSERT)
        begin
            jc      = j_reg + PW'(1);
            if (jc == i_reg - PW'(1))
                jc = i_reg + PW'(2);
            row_end = jc > n_eff;
        end
        else
        begin
            jc      = j_reg + PW'(1);
            row_end = jc > n_eff - PW'(1);
        end
        i_nx      = row_end ? i_reg + PW'(1) : i_reg;
        j_nx      = row_end ? first_j(neighborhood_reg, i_reg + PW'(1)) : jc;
        scan_last = row_end && (i_reg + PW'(2) >= n_eff);
    end

    // move application as a chain of position exchanges
    always_comb
    begin
        sw_x_init = bi_f;
        if (neighborhood_reg != tss_pkg::NB_INSERT)
            sw_y_init = bj_f;
        else if (bj_f > bi_f)
            sw_y_init = bi_f + PW'(1);
        else
            sw_y_init = bi_f - PW'(1);

        if (neighborhood_reg == tss_pkg::NB_REVERSE)
        begin
            sw_x_nx = sw_x_reg + PW'(1);
            sw_y_nx = sw_y_reg - PW'(1);
            sw_more = sw_x_nx < sw_y_nx;
        end
        else if (neighborhood_reg == tss_pkg::NB_SWAP)
        begin
            sw_x_nx = sw_x_reg;
            sw_y_nx = sw_y_reg;
            sw_more = 1'b0;
        end
        else if (bj_reg > bi_reg)
        begin
            sw_x_nx = sw_x_reg + PW'(1);
            sw_y_nx = sw_y_reg + PW'(1);
            sw_more = sw_y_nx < bj_reg;
        end
        else
        begin
            sw_x_nx = sw_x_reg - PW'(1);
            sw_y_nx = sw_y_reg - PW'(1);
            sw_more = sw_x_nx > bj_reg;
        end
    end

    // cost update and tenure division
    always_comb
    begin
        nc_full = cur_ext + {bestd_reg[AW-1], bestd_reg};
        if (nc_full[AW])
            nc_sat = '0;
        else if (nc_full > $signed({{(AW+1-tss_pkg::COST_W){1'b0}}, tss_pkg::COST_MAX}))
            nc_sat = tss_pkg::COST_MAX;
        else
            nc_sat = nc_full[tss_pkg::COST_W-1:0];
        improved_c = nc_sat < best_cost_reg;

        dvs        = (intensify_divisor_reg == '0) ? TW'(1) : intensify_divisor_reg;
        div_sh     = {div_rem_reg, div_num_reg[TW-1]};
        div_ge     = div_sh >= {1'b0, dvs};
        div_rem_nx = div_ge ? TW'(div_sh - {1'b0, dvs}) : div_sh[TW-1:0];
        div_q_nx   = {div_q_reg[TW-2:0], div_ge};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.command == tss_pkg::CMD_BEGIN)
                        state_next = tss_pkg::ST_COPY;
                    else if (req.command == tss_pkg::CMD_STEP && neighborhood_reg <= 2'd2)
                        state_next = tss_pkg::ST_TERM_P;
                    else if (req.command == tss_pkg::CMD_READ_CUR ||
                             req.command == tss_pkg::CMD_READ_BEST)
                        state_next = tss_pkg::ST_RD_WAIT;
                    else
                        state_next = tss_pkg::ST_DONE;
                end
            end
            tss_pkg::ST_RD_WAIT:  state_next = tss_pkg::ST_DONE;
            tss_pkg::ST_COPY:
            begin
                if (cp_reg == PW'(tss_pkg::MAX_CITIES + 1))
                    state_next = copy_div_reg ? tss_pkg::ST_DIV : tss_pkg::ST_DONE;
            end
            tss_pkg::ST_TERM_P:   state_next = tss_pkg::ST_TERM_Q;
            tss_pkg::ST_TERM_Q:   state_next = tss_pkg::ST_TERM_D;
            tss_pkg::ST_TERM_D:   state_next = tss_pkg::ST_TERM_ACC;
            tss_pkg::ST_TERM_ACC:
                state_next = (t_reg == t_last) ? tss_pkg::ST_EVAL : tss_pkg::ST_TERM_P;
            tss_pkg::ST_EVAL:
            begin
                if (!scan_last)
                    state_next = tss_pkg::ST_TERM_P;
                else
                    state_next = have_after ? tss_pkg::ST_SW_RX : tss_pkg::ST_DONE;
            end
            tss_pkg::ST_SW_RX:    state_next = tss_pkg::ST_SW_RY;
            tss_pkg::ST_SW_RY:    state_next = tss_pkg::ST_SW_WX;
            tss_pkg::ST_SW_WX:    state_next = tss_pkg::ST_SW_WY;
            tss_pkg::ST_SW_WY:
                state_next = sw_more ? tss_pkg::ST_SW_RX : tss_pkg::ST_UPDATE;
            tss_pkg::ST_UPDATE:
                state_next = improved_c ? tss_pkg::ST_COPY : tss_pkg::ST_DONE;
            tss_pkg::ST_DIV:
                state_next = (div_cnt_reg == 3'(TW - 1)) ? tss_pkg::ST_DONE : tss_pkg::ST_DIV;
            tss_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = tss_pkg::ST_IDLE;
            end
        endcase
    end

    // memory, tabu and handshake controls
    always_comb
    begin
        req.ready  = (state_reg == tss_pkg::ST_IDLE);
        dist_we    = accept && req.command == tss_pkg::CMD_LOAD_DIST;
        dist_waddr = {req.from_city, req.to_city};
        dist_raddr = {city_p_reg, cur_rdata};

        cur_we     = 1'b0;
        cur_waddr  = req.route_position;
        cur_wdata  = req.route_city;
        cur_raddr  = '0;
        best_we    = 1'b0;
        best_waddr = cp_reg - PW'(1);
        best_raddr = req_pos;

        tabu_ctl.clear  = accept && req.command == tss_pkg::CMD_BEGIN;
        tabu_ctl.record = (state_reg == tss_pkg::ST_UPDATE);
        tabu_ctl.city_a = best_ca_reg;
        tabu_ctl.city_b = best_cb_reg;
        tabu_ctl.tenure = active_tenure_reg;

        unique case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                cur_raddr = req_pos;
                cur_we    = accept && req.command == tss_pkg::CMD_LOAD_TOUR &&
                            req.route_position <= PW'(tss_pkg::MAX_CITIES);
            end
            tss_pkg::ST_COPY:
            begin
                cur_raddr = (cp_reg > PW'(tss_pkg::MAX_CITIES)) ? '0 : cp_reg;
                best_we   = (cp_reg != '0);
            end
            tss_pkg::ST_TERM_P: cur_raddr = p_pos;
            tss_pkg::ST_TERM_Q: cur_raddr = q_pos;
            tss_pkg::ST_SW_RX:  cur_raddr = sw_x_reg;
            tss_pkg::ST_SW_RY:  cur_raddr = sw_y_reg;
            tss_pkg::ST_SW_WX:
            begin
                cur_we    = 1'b1;
                cur_waddr = sw_x_reg;
                cur_wdata = cur_rdata;
            end
            tss_pkg::ST_SW_WY:
            begin
                cur_we    = 1'b1;
                cur_waddr = sw_y_reg;
                cur_wdata = sw_t_reg;
            end
            tss_pkg::ST_RD_WAIT, tss_pkg::ST_TERM_D, tss_pkg::ST_TERM_ACC,
            tss_pkg::ST_EVAL, tss_pkg::ST_UPDATE, tss_pkg::ST_DIV, tss_pkg::ST_DONE:
                cur_raddr = '0;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= tss_pkg::ST_IDLE;
            neighborhood_reg      <= tss_pkg::NB_REVERSE;
            city_count_reg        <= PW'(4);
            tabu_tenure_reg       <= TW'(8);
            intensify_divisor_reg <= TW'(2);
            current_cost_reg      <= '0;
            best_cost_reg         <= '0;
            active_tenure_reg     <= TW'(8);
            stall_counter_reg     <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tss_pkg::CFG_NEIGHBORHOOD: neighborhood_reg      <= cfg_data[1:0];
                    tss_pkg::CFG_CITY_COUNT:   city_count_reg        <= cfg_data;
                    tss_pkg::CFG_TENURE:       tabu_tenure_reg       <= cfg_data[TW-1:0];
                    tss_pkg::CFG_DIVISOR:      intensify_divisor_reg <= cfg_data[TW-1:0];
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            if (accept && req.command == tss_pkg::CMD_BEGIN)
            begin
                current_cost_reg  <= req.initial_cost;
                best_cost_reg     <= req.initial_cost;
                active_tenure_reg <= tss_pkg::clamp_tenure(tabu_tenure_reg);
                stall_counter_reg <= '0;
            end

            if (state_reg == tss_pkg::ST_UPDATE)
            begin
                current_cost_reg <= nc_sat;
                if (improved_c)
                begin
                    best_cost_reg     <= nc_sat;
                    stall_counter_reg <= '0;
                end
                else if (stall_counter_reg != '1)
                    stall_counter_reg <= stall_counter_reg + tss_pkg::STALL_W'(1);
            end

            if (state_reg == tss_pkg::ST_DIV && div_cnt_reg == 3'(TW - 1))
                active_tenure_reg <= tss_pkg::clamp_tenure(div_q_nx);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg          <= req.command;
                    pos_reg          <= req.route_position;
                    res_found_reg    <= 1'b0;
                    res_improved_reg <= 1'b0;
                    res_city_reg     <= '0;
                    i_reg            <= PW'(1);
                    j_reg            <= first_j(neighborhood_reg, PW'(1));
                    t_reg            <= '0;
                    acc_reg          <= '0;
                    s_acc_reg        <= '0;
                    have_reg         <= 1'b0;
                    cp_reg           <= '0;
                    copy_div_reg     <= 1'b0;
                end
            end
            tss_pkg::ST_RD_WAIT:
            begin
                if (pos_reg > PW'(tss_pkg::MAX_CITIES))
                    res_city_reg <= '0;
                else if (cmd_reg == tss_pkg::CMD_READ_CUR)
                    res_city_reg <= cur_rdata;
                else
                    res_city_reg <= best_rdata;
            end
            tss_pkg::ST_COPY:
                cp_reg <= cp_reg + PW'(1);
            tss_pkg::ST_TERM_P:
                ;
            tss_pkg::ST_TERM_Q:
            begin
                // tour data here is the city at the term's first position
                city_p_reg <= cur_rdata;
                if (term.p_sel == tss_pkg::PS_I)
                    ca_reg <= cur_rdata;
                if (term.p_sel == cb_sel)
                    cb_reg <= cur_rdata;
            end
            tss_pkg::ST_TERM_D:
            begin
                if (term.q_sel == tss_pkg::PS_I)
                    ca_reg <= cur_rdata;
                if (term.q_sel == cb_sel)
                    cb_reg <= cur_rdata;
            end
            tss_pkg::ST_TERM_ACC:
            begin
                if (term.to_s)
                    s_acc_reg <= term.neg ? s_acc_reg - dist_term : s_acc_reg + dist_term;
                else
                    acc_reg <= term.neg ? acc_reg - dist_term : acc_reg + dist_term;
                t_reg <= (t_reg == t_last) ? 3'd0 : t_reg + 3'd1;
            end
            tss_pkg::ST_EVAL:
            begin
                if (take)
                begin
                    have_reg    <= 1'b1;
                    bestd_reg   <= delta_c;
                    bi_reg      <= i_reg;
                    bj_reg      <= j_reg;
                    best_ca_reg <= ca_reg;
                    best_cb_reg <= cb_reg;
                end
                acc_reg <= '0;
                i_reg   <= i_nx;
                j_reg   <= j_nx;
                if (row_end)
                    s_acc_reg <= '0;
                sw_x_reg <= sw_x_init;
                sw_y_reg <= sw_y_init;
            end
            tss_pkg::ST_SW_RX:
                ;
            tss_pkg::ST_SW_RY:
                sw_t_reg <= cur_rdata;
            tss_pkg::ST_SW_WX:
                ;
            tss_pkg::ST_SW_WY:
            begin
                sw_x_reg <= sw_x_nx;
                sw_y_reg <= sw_y_nx;
            end
            tss_pkg::ST_UPDATE:
            begin
                res_found_reg    <= 1'b1;
                res_improved_reg <= improved_c;
                cp_reg           <= '0;
                copy_div_reg     <= 1'b1;
                div_num_reg      <= tabu_tenure_reg;
                div_rem_reg      <= '0;
                div_q_reg        <= '0;
                div_cnt_reg      <= '0;
            end
            tss_pkg::ST_DIV:
            begin
                div_num_reg <= {div_num_reg[TW-2:0], 1'b0};
                div_rem_reg <= div_rem_nx;
                div_q_reg   <= div_q_nx;
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end
            tss_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_found_reg    <= res_found_reg;
                    out_first_reg    <= res_found_reg ? bi_reg : '0;
                    out_second_reg   <= res_found_reg ? bj_reg : '0;
                    out_delta_reg    <= res_found_reg ? bestd_reg[tss_pkg::DELTA_W-1:0] : '0;
                    out_cur_reg      <= current_cost_reg;
                    out_best_reg     <= best_cost_reg;
                    out_improved_reg <= res_improved_reg;
                    out_stall_reg    <= stall_counter_reg;
                    out_city_reg     <= res_city_reg;
                end
            end
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.move_found   = out_found_reg;
    assign rsp.move_first   = out_first_reg;
    assign rsp.move_second  = out_second_reg;
    assign rsp.move_delta   = out_delta_reg;
    assign rsp.current_cost = out_cur_reg;
    assign rsp.best_cost    = out_best_reg;
    assign rsp.improved     = out_improved_reg;
    assign rsp.stall_count  = out_stall_reg;
    assign rsp.read_city    = out_city_reg;

    // the best cost never lies above the current cost
    assert property (@(posedge clk) disable iff (!rst_n)
        best_cost_reg <= current_cost_reg)
        else $error("best cost above current cost");

    assert property (@(posedge clk) disable iff (!rst_n)
        active_tenure_reg != '0 && active_tenure_reg <= TW'(tss_pkg::TABU_DEPTH))
        else $error("active tenure out of range");

    // an exchange never pairs a position with itself
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tss_pkg::ST_SW_RX |-> sw_x_reg != sw_y_reg)
        else $error("degenerate exchange");

    // a finished step hands over a result before the next item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tss_pkg::ST_UPDATE |=>
            state_reg == tss_pkg::ST_COPY || state_reg == tss_pkg::ST_DONE)
        else $error("update not followed by copy or result");

endmodule
